FILE: sv/trilinear_volume_sampler_top_assert.svh
// assertion helpers for the sampler top module
`ifndef TRILINEAR_VOLUME_SAMPLER_TOP_ASSERT_SVH
`define TRILINEAR_VOLUME_SAMPLER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TVS_ASSERT_NOW(lbl, clk, rstn, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TVS_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: sv/tvs_pkg.sv
`default_nettype none
package tvs_pkg;

  localparam int AXIS_MAX    = 32;
  localparam int VOXEL_BITS  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int STORE_DEPTH = 32768;

  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int POS_W    = 13;
  localparam int INT_W    = POS_W - FRAC_BITS;
  localparam int SIZE_W   = 6;
  localparam int IDX_W    = $clog2(AXIS_MAX);
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_e;

  typedef logic signed [VOXEL_BITS-1:0] voxel_t;
  typedef logic [FRAC_BITS-1:0]         frac_t;
  typedef logic [POS_W-1:0]             pos_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [SIZE_W-1:0]            size_t;

  typedef struct packed {
    size_t sx;
    size_t sy;
    size_t sz;
  } size_set_t;

  typedef struct packed {
    frac_t fx;
    frac_t fy;
    frac_t fz;
  } frac_set_t;

  // grid extent actually used along one axis
  function automatic size_t eff_size(size_t r);
    size_t s;
    if (r < size_t'(2)) s = size_t'(2);
    else if (r > size_t'(AXIS_MAX)) s = size_t'(AXIS_MAX);
    else s = r;
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: sv/tvs_voxel_ram.sv
`default_nettype none
module tvs_voxel_ram #(
  parameter int DEPTH  = 32768,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

FILE: sv/tvs_addr_gen.sv
`default_nettype none
module tvs_addr_gen (
  input  wire logic               clk_i,
  input  wire logic               load_i,
  input  wire tvs_pkg::pos_t      pos_x_i,
  input  wire tvs_pkg::pos_t      pos_y_i,
  input  wire tvs_pkg::pos_t      pos_z_i,
  input  wire tvs_pkg::size_set_t sizes_i,
  input  wire logic [2:0]         corner_i,
  output tvs_pkg::addr_t          addr_o,
  output tvs_pkg::frac_set_t      frac_o
);
  import tvs_pkg::*;

  localparam int SXY_W   = 2 * SIZE_W;
  localparam int PLANE_W = IDX_W + SXY_W;
  localparam int ROW_W   = IDX_W + SIZE_W;

  pos_t px_q, py_q, pz_q;
  logic [IDX_W-1:0] i0_d, i1_d, j0_d, j1_d, k0_d, k1_d;
  logic [IDX_W-1:0] i0_q, i1_q, j0_q, j1_q, k0_q, k1_q;
  logic [SXY_W-1:0] sxy_q;
  size_t sx, sy, sz;
  addr_t plane0_q, plane1_q, row0_q, row1_q;
  logic [IDX_W-1:0] i0_r, i1_r;
  addr_t plane, row;
  logic [IDX_W-1:0] col;

  // integer part clamped into the grid, upper neighbor clamped at the last plane
  function automatic void split_axis(input pos_t p, input size_t s,
                                     output logic [IDX_W-1:0] lo,
                                     output logic [IDX_W-1:0] hi);
    logic [INT_W-1:0] ip;
    size_t            sm1;
    ip  = p[POS_W-1:FRAC_BITS];
    sm1 = s - size_t'(1);
    if (size_t'(ip) > sm1) lo = IDX_W'(sm1);
    else lo = IDX_W'(ip);
    if (size_t'(lo) == sm1) hi = IDX_W'(sm1);
    else hi = lo + IDX_W'(1);
  endfunction

  always_comb begin
    sx = eff_size(sizes_i.sx);
    sy = eff_size(sizes_i.sy);
    sz = eff_size(sizes_i.sz);
    split_axis(px_q, sx, i0_d, i1_d);
    split_axis(py_q, sy, j0_d, j1_d);
    split_axis(pz_q, sz, k0_d, k1_d);
  end

  // position held for the whole sample, the two stages below just follow it
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
    end
    i0_q  <= i0_d;
    i1_q  <= i1_d;
    j0_q  <= j0_d;
    j1_q  <= j1_d;
    k0_q  <= k0_d;
    k1_q  <= k1_d;
    sxy_q <= SXY_W'(sx) * SXY_W'(sy);
    plane0_q <= ADDR_W'(PLANE_W'(k0_q) * PLANE_W'(sxy_q));
    plane1_q <= ADDR_W'(PLANE_W'(k1_q) * PLANE_W'(sxy_q));
    row0_q   <= ADDR_W'(ROW_W'(j0_q) * ROW_W'(sx));
    row1_q   <= ADDR_W'(ROW_W'(j1_q) * ROW_W'(sx));
    i0_r     <= i0_q;
    i1_r     <= i1_q;
  end

  // corner bit 0 picks x hi, bit 1 y hi, bit 2 z hi
  always_comb begin
    plane  = corner_i[2] ? plane1_q : plane0_q;
    row    = corner_i[1] ? row1_q : row0_q;
    col    = corner_i[0] ? i1_r : i0_r;
    addr_o = plane + row + addr_t'(col);
    frac_o.fx = px_q[FRAC_BITS-1:0];
    frac_o.fy = py_q[FRAC_BITS-1:0];
    frac_o.fz = pz_q[FRAC_BITS-1:0];
  end

endmodule
`default_nettype wire

FILE: sv/tvs_lerp.sv
`default_nettype none
module tvs_lerp (
  input  wire tvs_pkg::voxel_t a_i,
  input  wire tvs_pkg::voxel_t b_i,
  input  wire tvs_pkg::frac_t  f_i,
  output tvs_pkg::voxel_t      y_o
);
  import tvs_pkg::*;

  localparam int PW = VOXEL_BITS + FRAC_BITS + 2;

  logic signed [VOXEL_BITS:0] diff;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       acc;
  logic signed [PW-1:0]       step;

  // a*(S-f) + b*f = a*S + (b-a)*f, so only one product is needed
  always_comb begin
    diff = $signed({b_i[VOXEL_BITS-1], b_i}) - $signed({a_i[VOXEL_BITS-1], a_i});
    prod = PW'(diff) * PW'($signed({1'b0, f_i}));
    acc  = prod + PW'(1 << (FRAC_BITS - 1));
    step = acc >>> FRAC_BITS;
    y_o  = a_i + step[VOXEL_BITS-1:0];
  end

endmodule
`default_nettype wire

FILE: sv/trilinear_volume_sampler_top.sv
`default_nettype none
// Trilinear volume sampler. A write beat (func 0) stores one Q8.8 voxel; the
// block is ready again in the next cycle. A sample beat (func 1) keeps the
// block busy until its result moves to the output register: ST_SPLIT and
// ST_BASE split the position and form the plane and row offsets, ST_FETCH
// reads the eight corners through the single port of the voxel memory,
// ST_LAST lands the last read, ST_LERP runs seven interpolations on the
// shared interpolation unit (four along x, two along y, one along z) and
// ST_DONE moves the result into the output register. The output register
// holds a finished sample while the next beat is worked on; a sample finishing
// while the previous one is still stalled waits for it.
// The voxel memory is not cleared at reset; only written voxels may be read.
module trilinear_volume_sampler_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           func_i,
  input  wire logic [tvs_pkg::ADDR_W-1:0]     voxel_addr_i,
  input  wire logic signed [tvs_pkg::SAMPLE_W-1:0] voxel_value_i,
  input  wire logic [tvs_pkg::POS_W-1:0]      pos_x_i,
  input  wire logic [tvs_pkg::POS_W-1:0]      pos_y_i,
  input  wire logic [tvs_pkg::POS_W-1:0]      pos_z_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [tvs_pkg::SAMPLE_W-1:0] sample_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [tvs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tvs_pkg::SIZE_W-1:0]     cfg_wdata_i
);
  import tvs_pkg::*;

  `include "trilinear_volume_sampler_top_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_BASE,
    ST_FETCH,
    ST_LAST,
    ST_LERP,
    ST_DONE
  } state_e;

  localparam logic [2:0] LAST_CORNER = 3'd7;
  localparam logic [2:0] LAST_OP     = 3'd6;

  state_e    state_q;
  logic [2:0] cnt_q;
  logic [2:0] op_q;
  logic       rd_pend_q;
  logic [2:0] rd_idx_q;
  voxel_t     v_q [8];
  voxel_t     t_q [7];
  logic       out_valid_q;
  voxel_t     sample_q;
  size_set_t  sizes_q;

  logic       in_accept;
  logic       done_fire;
  logic       mem_we;
  addr_t      mem_addr;
  addr_t      corner_addr;
  voxel_t     mem_rdata;
  frac_set_t  frac;
  voxel_t     lerp_a, lerp_b, lerp_y;
  frac_t      lerp_f;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign mem_we      = in_accept && (func_i == FUNC_WRITE);
  assign mem_addr    = (state_q == ST_FETCH) ? corner_addr : voxel_addr_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  // finished sample moves out when the output register is free or draining
  assign done_fire   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  tvs_voxel_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (VOXEL_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (voxel_value_i),
    .rdata_o (mem_rdata)
  );

  tvs_addr_gen u_addr (
    .clk_i    (clk_i),
    .load_i   (in_accept && (func_i == FUNC_SAMPLE)),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .pos_z_i  (pos_z_i),
    .sizes_i  (sizes_q),
    .corner_i (cnt_q),
    .addr_o   (corner_addr),
    .frac_o   (frac)
  );

  // x lerps pair up corners, then y and z combine earlier results
  always_comb begin
    case (op_q)
      3'd0: begin lerp_a = v_q[0]; lerp_b = v_q[1]; lerp_f = frac.fx; end
      3'd1: begin lerp_a = v_q[2]; lerp_b = v_q[3]; lerp_f = frac.fx; end
      3'd2: begin lerp_a = v_q[4]; lerp_b = v_q[5]; lerp_f = frac.fx; end
      3'd3: begin lerp_a = v_q[6]; lerp_b = v_q[7]; lerp_f = frac.fx; end
      3'd4: begin lerp_a = t_q[0]; lerp_b = t_q[1]; lerp_f = frac.fy; end
      3'd5: begin lerp_a = t_q[2]; lerp_b = t_q[3]; lerp_f = frac.fy; end
      3'd6: begin lerp_a = t_q[4]; lerp_b = t_q[5]; lerp_f = frac.fz; end
      default: begin lerp_a = '0; lerp_b = '0; lerp_f = '0; end
    endcase
  end

  tvs_lerp u_lerp (
    .a_i (lerp_a),
    .b_i (lerp_b),
    .f_i (lerp_f),
    .y_o (lerp_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      op_q        <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      sizes_q.sx  <= size_t'(AXIS_MAX);
      sizes_q.sy  <= size_t'(AXIS_MAX);
      sizes_q.sz  <= size_t'(AXIS_MAX);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SIZE_X: sizes_q.sx <= cfg_wdata_i;
          CFG_SIZE_Y: sizes_q.sy <= cfg_wdata_i;
          CFG_SIZE_Z: sizes_q.sz <= cfg_wdata_i;
          default: ;
        endcase
      end

      rd_pend_q <= (state_q == ST_FETCH);
      rd_idx_q  <= cnt_q;
      if (rd_pend_q) begin
        v_q[rd_idx_q] <= mem_rdata;
      end

      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept && (func_i == FUNC_SAMPLE)) begin
            state_q <= ST_SPLIT;
          end
        end
        ST_SPLIT: state_q <= ST_BASE;
        ST_BASE: begin
          cnt_q   <= '0;
          state_q <= ST_FETCH;
        end
        ST_FETCH: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == LAST_CORNER) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          op_q    <= '0;
          state_q <= ST_LERP;
        end
        ST_LERP: begin
          t_q[op_q] <= lerp_y;
          op_q      <= op_q + 3'd1;
          if (op_q == LAST_OP) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_fire) begin
            sample_q <= t_q[6];
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `TVS_ASSERT_NOW(a_write_only_idle, clk_i, rst_ni, mem_we, state_q == ST_IDLE, "voxel write while busy")
  `TVS_ASSERT_NOW(a_no_read_in_flight, clk_i, rst_ni, !in_stall_o, !rd_pend_q, "ready with a corner read outstanding")
  `TVS_ASSERT_NEXT(a_fetch_lands, clk_i, rst_ni, state_q == ST_FETCH, rd_pend_q && (rd_idx_q == $past(cnt_q)), "corner read not tracked")
  `TVS_ASSERT_NEXT(a_done_delivers, clk_i, rst_ni, (state_q == ST_DONE) && !out_valid_q, out_valid_q && (state_q == ST_IDLE), "finished sample not presented")

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tvs_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic   func;
    addr_t  addr;
    voxel_t value;
    pos_t   px;
    pos_t   py;
    pos_t   pz;
  } vol_op_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  func = FUNC_WRITE;
  addr_t                 voxel_addr = '0;
  voxel_t                voxel_value = '0;
  pos_t                  pos_x = '0;
  pos_t                  pos_y = '0;
  pos_t                  pos_z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [15:0]    sample_out;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [SIZE_W-1:0]     cfg_wdata = '0;

  trilinear_volume_sampler_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .voxel_addr_i (voxel_addr),
    .voxel_value_i(voxel_value),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pos_z_i      (pos_z),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_o     (sample_out),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // volume contents and grid extents as the block should see them
  voxel_t  vox_mem [STORE_DEPTH];
  bit      vox_seen [STORE_DEPTH];
  size_t   extent_reg [3] = '{size_t'(32), size_t'(32), size_t'(32)};

  vol_op_t pending [$];
  voxel_t  sample_q [$];

  int  fault_count = 0;
  int  phase_items;
  int  hold_requests = 0;
  int  hold_served = 0;
  bit  calm = 1'b0;

  function automatic int axis_extent(size_t r);
    if (r < 2) return 2;
    if (r > AXIS_MAX) return AXIS_MAX;
    return int'(r);
  endfunction

  // floored index along one axis, clamped to the grid; upper picks the next plane
  function automatic int axis_index(pos_t p, int s, bit upper);
    int ip;
    ip = int'(p >> FRAC_BITS);
    if (ip > s - 1) ip = s - 1;
    if (upper && ip < s - 1) ip = ip + 1;
    return ip;
  endfunction

  // corner c: bit 0 selects upper x, bit 1 upper y, bit 2 upper z
  function automatic addr_t corner_addr(int c, pos_t px, pos_t py, pos_t pz);
    int sx, sy, sz, i, j, k;
    sx = axis_extent(extent_reg[0]);
    sy = axis_extent(extent_reg[1]);
    sz = axis_extent(extent_reg[2]);
    i = axis_index(px, sx, c[0]);
    j = axis_index(py, sy, c[1]);
    k = axis_index(pz, sz, c[2]);
    return addr_t'(k * sx * sy + j * sx + i);
  endfunction

  // rounds half up, floor division by the fraction scale
  function automatic int blend(int a, int b, int f);
    int acc;
    acc = a * ((1 << FRAC_BITS) - f) + b * f + (1 << (FRAC_BITS - 1));
    return acc >>> FRAC_BITS;
  endfunction

  function automatic voxel_t trilerp(pos_t px, pos_t py, pos_t pz);
    int v [8];
    int row [4];
    int lo_z, hi_z, r;
    for (int c = 0; c < 8; c++) v[c] = int'(vox_mem[corner_addr(c, px, py, pz)]);
    for (int n = 0; n < 4; n++) row[n] = blend(v[2*n], v[2*n+1], int'(px[FRAC_BITS-1:0]));
    lo_z = blend(row[0], row[1], int'(py[FRAC_BITS-1:0]));
    hi_z = blend(row[2], row[3], int'(py[FRAC_BITS-1:0]));
    r = blend(lo_z, hi_z, int'(pz[FRAC_BITS-1:0]));
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return voxel_t'(r);
  endfunction

  function automatic void apply_beat(vol_op_t op);
    if (op.func == FUNC_WRITE) vox_mem[op.addr] = op.value;
    else sample_q.insert(sample_q.size(), trilerp(op.px, op.py, op.pz));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic voxel_t pick_voxel();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    return voxel_t'($urandom);
  endfunction

  function automatic pos_t pick_pos(int s);
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0: return pos_t'($urandom);
      1: return {INT_W'($urandom), FRAC_BITS'(0)};
      2: return {INT_W'($urandom), {FRAC_BITS{1'b1}}};
      3: return {INT_W'(s - 1), FRAC_BITS'($urandom)};
      default: return {INT_W'($urandom_range(0, 3)), FRAC_BITS'($urandom)};
    endcase
  endfunction

  task automatic queue_write(addr_t a, voxel_t v);
    vol_op_t op;
    op.func = FUNC_WRITE;
    op.addr = a;
    op.value = v;
    op.px = pos_t'($urandom);
    op.py = pos_t'($urandom);
    op.pz = pos_t'($urandom);
    pending.insert(pending.size(), op);
    vox_seen[a] = 1'b1;
    phase_items++;
  endtask

  // fills any corner not yet written before the sample goes out
  task automatic queue_sample(pos_t px, pos_t py, pos_t pz);
    vol_op_t op;
    addr_t a;
    for (int c = 0; c < 8; c++) begin
      a = corner_addr(c, px, py, pz);
      if (!vox_seen[a]) queue_write(a, pick_voxel());
    end
    op.func = FUNC_SAMPLE;
    op.addr = addr_t'($urandom);
    op.value = voxel_t'($urandom);
    op.px = px;
    op.py = py;
    op.pz = pz;
    pending.insert(pending.size(), op);
    phase_items++;
  endtask

  task automatic queue_random(int quota);
    int r;
    phase_items = 0;
    while (phase_items < quota) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        queue_write(addr_t'($urandom), pick_voxel());
      end else if (r < 3) begin
        queue_write(corner_addr($urandom_range(0, 7), pick_pos(32), pick_pos(32),
                                pick_pos(32)), pick_voxel());
      end else begin
        queue_sample(pick_pos(axis_extent(extent_reg[0])),
                     pick_pos(axis_extent(extent_reg[1])),
                     pick_pos(axis_extent(extent_reg[2])));
      end
    end
  endtask

  task automatic set_extent(cfg_idx_e idx, size_t v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    extent_reg[idx] = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid || sample_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void log_fault(string what, voxel_t want, logic [15:0] got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s expected %h got %h", $realtime, what, want, got);
  endfunction

  // driver
  int     send_gap = 0;
  vol_op_t cur_op;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_beat(cur_op);
        send_gap = pick_gap();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && pending.size() != 0) begin
          cur_op = pending.pop_front();
          func <= cur_op.func;
          voxel_addr <= cur_op.addr;
          voxel_value <= cur_op.value;
          pos_x <= cur_op.px;
          pos_y <= cur_op.py;
          pos_z <= cur_op.pz;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // monitor and receiver stalls
  int rx_wait = 0;
  int hold_left = 0;
  voxel_t want;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          log_fault("unexpected sample beat:", '0, sample_out);
        end else begin
          want = sample_q.pop_front();
          if (sample_out !== want) log_fault("sample mismatch:", want, sample_out);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        rx_wait = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

  int plan [7][3] = '{'{2, 2, 2}, '{0, 1, 63}, '{5, 7, 3}, '{32, 32, 32},
                      '{63, 33, 17}, '{2, 32, 2}, '{32, 2, 32}};

  initial begin
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;

    // origin cell with corners at opposite extremes
    phase_items = 0;
    for (int c = 0; c < 8; c++)
      queue_write(corner_addr(c, '0, '0, '0),
                  ((c ^ (c >> 1) ^ (c >> 2)) & 1) ? 16'sh8000 : 16'sh7FFF);
    queue_sample('0, '0, '0);
    queue_sample(pos_t'(128), pos_t'(128), pos_t'(128));
    queue_sample(pos_t'(255), pos_t'(255), pos_t'(255));
    queue_sample(pos_t'(128), '0, '0);
    queue_sample(pos_t'(1), pos_t'(255), '0);
    // far corner: last plane on all axes folds onto one voxel
    queue_write(addr_t'(STORE_DEPTH - 1), 16'sh8000);
    queue_sample('1, '1, '1);
    queue_sample(pos_t'(31 << FRAC_BITS), pos_t'(31 << FRAC_BITS), pos_t'(31 << FRAC_BITS));
    queue_sample(pos_t'((30 << FRAC_BITS) + 64), pos_t'((30 << FRAC_BITS) + 192),
                 pos_t'((30 << FRAC_BITS) + 128));
    queue_random(60);
    drain();

    for (int p = 0; p < 9; p++) begin
      calm = (p == 1 || p == 5);
      if (p < 7) begin
        set_extent(CFG_SIZE_X, size_t'(plan[p][0]));
        set_extent(CFG_SIZE_Y, size_t'(plan[p][1]));
        set_extent(CFG_SIZE_Z, size_t'(plan[p][2]));
      end else begin
        set_extent(CFG_SIZE_X, size_t'($urandom));
        set_extent(CFG_SIZE_Y, size_t'($urandom));
        set_extent(CFG_SIZE_Z, size_t'($urandom));
      end
      @(negedge clk_i);
      // long output hold-off so the block backs up into its input
      if (p == 3) hold_requests++;
      queue_random(p == 3 ? 80 : 40);
      drain();
    end

    if (fault_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/tvs_pkg.sv
sv/tvs_voxel_ram.sv
sv/tvs_addr_gen.sv
sv/tvs_lerp.sv
sv/trilinear_volume_sampler_top.sv
bench/tb_top.sv
